[src/fifo_replacement_cache_assert.svh]
// assertion macros for the fifo replacement cache
// used by the port checker, no other dependencies
`ifndef FIFO_REPLACEMENT_CACHE_ASSERT_SVH
`define FIFO_REPLACEMENT_CACHE_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define FRC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FRC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/frc_pkg.sv]
// shared types and constants of the fifo replacement cache
// no dependencies
`default_nettype none

package frc_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 4;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 3'd0,
        ST_EVICTED = 3'd1,
        ST_HIT     = 3'd2,
        ST_MISS    = 3'd3,
        ST_DELETED = 3'd4
    } status_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic live;
        logic take_new;
        logic take_next;
    } cell_ctl_t;

endpackage

`default_nettype wire

[src/frc_cell.sv]
// one entry cell of the fifo replacement cache row
// depends on frc_pkg
`default_nettype none

module frc_cell (
    input  wire logic                           aclk,
    input  wire frc_pkg::cell_ctl_t             ctl,
    input  wire logic [frc_pkg::WORD_W-1:0]     new_key,
    input  wire logic [frc_pkg::WORD_W-1:0]     new_value,
    input  wire logic [frc_pkg::WORD_W-1:0]     next_key,
    input  wire logic [frc_pkg::WORD_W-1:0]     next_value,
    input  wire logic [frc_pkg::WORD_W-1:0]     probe_key,
    output logic      [frc_pkg::WORD_W-1:0]     key_q,
    output logic      [frc_pkg::WORD_W-1:0]     value_q,
    output logic                                match
);

    logic [frc_pkg::WORD_W-1:0] key_reg;
    logic [frc_pkg::WORD_W-1:0] value_reg;

    // new entry wins over a shift from the younger neighbour
    always_ff @(posedge aclk) begin
        if (ctl.take_new) begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end else if (ctl.take_next) begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

    assign match   = ctl.live & (key_reg == probe_key);
    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

`default_nettype wire

[src/fifo_replacement_cache.sv]
// flow: an input transfer latches the payload registers, then the exec state compares and shifts
// the cell row and loads the result registers, which raise output valid (latch, then compare and shift)
// a new item is not taken while one is in the latch or exec state, so one item is in flight at a time;
// the next item is taken only once the result register is free or being freed
// reset (aresetn low, synchronous) empties the store and clears the sequencer and output valid
// entry contents are not reset; cells at or above the fill count are never matched
`default_nettype none

module fifo_replacement_cache #(
    parameter int DEPTH = frc_pkg::DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [frc_pkg::S_DATA_W-1:0]   s_tdata,  // key[31:0], data_in[63:32]
    input  wire logic [frc_pkg::CMD_W-1:0]      s_tuser,  // command[1:0]
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [frc_pkg::M_DATA_W-1:0]   m_tdata,  // data_out[31:0], occupancy[35:32], zero pad
    output logic      [frc_pkg::STATUS_W-1:0]   m_tuser   // status[2:0]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = frc_pkg::WORD_W;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    frc_pkg::cmd_t          cmd_reg;
    logic signed [W-1:0]    key_reg;
    logic signed [W-1:0]    data_reg;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   m_valid_reg, m_valid_next;
    frc_pkg::status_t       status_reg, status_next;
    logic [W-1:0]           dout_reg, dout_next;
    logic [frc_pkg::OCC_W-1:0] occ_reg, occ_next;

    // cell row wiring
    frc_pkg::cell_ctl_t     cell_ctl [DEPTH];
    logic [W-1:0]           cell_key [DEPTH];
    logic [W-1:0]           cell_val [DEPTH];
    logic [W-1:0]           nb_key   [DEPTH];
    logic [W-1:0]           nb_val   [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       first_hit;
    logic [DEPTH-1:0]       shift_mask;
    logic [DEPTH-1:0]       write_pos;
    logic [W-1:0]           hit_value;

    logic                   in_xfer;
    logic                   exec;
    logic                   hit;
    logic                   full;
    logic                   is_put;
    logic                   is_del;
    logic [CNT_W+frc_pkg::OCC_W-1:0] count_wide;

    assign in_xfer  = s_tvalid & s_tready;
    assign exec     = (state_reg == S_EXEC);
    // next item may enter once the output register is free or being freed
    assign s_tready = (state_reg == S_IDLE) & (~m_valid_reg | m_tready);

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign is_put = (cmd_reg == frc_pkg::CMD_PUT);
    assign is_del = (cmd_reg == frc_pkg::CMD_DEL);

    // oldest match: lowest set bit, and every cell from there on shifts on delete
    assign hit        = |match_vec;
    assign first_hit  = match_vec & (~match_vec + DEPTH'(1));
    assign shift_mask = hit ? ~(first_hit - DEPTH'(1)) : '0;

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_value = hit_value | (cell_val[i] & {W{first_hit[i]}});
        end
    end

    // the row of cells, each fed by its younger neighbour
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign nb_key[i] = '0;
            assign nb_val[i] = '0;
            // a put into a full store lands in the youngest cell
            assign write_pos[i] = full | (count_reg == CNT_W'(i));
        end else begin : g_body
            assign nb_key[i] = cell_key[i+1];
            assign nb_val[i] = cell_val[i+1];
            assign write_pos[i] = ~full & (count_reg == CNT_W'(i));
        end

        assign cell_ctl[i].live      = (CNT_W'(i) < count_reg);
        assign cell_ctl[i].take_new  = exec & is_put & write_pos[i];
        assign cell_ctl[i].take_next = exec & ((is_put & full) | (is_del & shift_mask[i]));

        frc_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .new_key    (key_reg),
            .new_value  (data_reg),
            .next_key   (nb_key[i]),
            .next_value (nb_val[i]),
            .probe_key  (key_reg),
            .key_q      (cell_key[i]),
            .value_q    (cell_val[i]),
            .match      (match_vec[i])
        );
    end

    // command decode and result
    always_comb begin
        status_next = frc_pkg::ST_MISS;
        dout_next   = '0;
        count_next  = count_reg;
        unique case (cmd_reg)
            frc_pkg::CMD_PUT: begin
                if (full) begin
                    status_next = frc_pkg::ST_EVICTED;
                end else begin
                    status_next = frc_pkg::ST_STORED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            frc_pkg::CMD_GET: begin
                if (hit) begin
                    status_next = frc_pkg::ST_HIT;
                    dout_next   = hit_value;
                end
            end
            frc_pkg::CMD_DEL: begin
                if (hit) begin
                    status_next = frc_pkg::ST_DELETED;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status_next = frc_pkg::ST_MISS;
            end
        endcase
    end

    // occupancy shows the low bits of the new count
    assign count_wide = {{frc_pkg::OCC_W{1'b0}}, count_next};
    assign occ_next   = count_wide[frc_pkg::OCC_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (exec) begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg  <= frc_pkg::cmd_t'(s_tuser);
            key_reg  <= s_tdata[W-1:0];
            data_reg <= s_tdata[2*W-1:W];
        end
        if (exec) begin
            status_reg <= status_next;
            dout_reg   <= dout_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(frc_pkg::M_DATA_W - W - frc_pkg::OCC_W){1'b0}}, occ_reg, dout_reg};

endmodule

`default_nettype wire

[src/frc_checker.sv]
// port-level checker for the fifo replacement cache, bound to the top level
// depends on frc_pkg and fifo_replacement_cache_assert.svh
`default_nettype none

`include "fifo_replacement_cache_assert.svh"

module frc_checker #(
    parameter int DEPTH = frc_pkg::DEPTH_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [frc_pkg::S_DATA_W-1:0]   s_tdata,
    input wire logic [frc_pkg::CMD_W-1:0]      s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [frc_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic [frc_pkg::STATUS_W-1:0]   m_tuser
);

    logic [frc_pkg::OCC_W-1:0] occ;
    logic [frc_pkg::WORD_W-1:0] dout;
    logic in_xfer;

    assign occ     = m_tdata[frc_pkg::WORD_W+frc_pkg::OCC_W-1:frc_pkg::WORD_W];
    assign dout    = m_tdata[frc_pkg::WORD_W-1:0];
    assign in_xfer = s_tvalid & s_tready & (s_tdata == s_tdata) & (s_tuser == s_tuser);

    // only a get hit carries a value
    `FRC_ASSERT_RST(a_dout_zero, aclk, aresetn, m_tvalid && (m_tuser != frc_pkg::ST_HIT) |-> dout == '0, "data_out not zero outside a get hit")

    // an eviction only happens with the store full
    `FRC_ASSERT_RST(a_evict_full, aclk, aresetn, m_tvalid && (m_tuser == frc_pkg::ST_EVICTED) |-> occ == 4'(DEPTH), "eviction without a full store")

    // one item in flight: a transfer in is followed by input refused, then a valid result
    `FRC_ASSERT_RST(a_latency, aclk, aresetn, in_xfer |=> !s_tready ##1 m_tvalid, "result not presented after input transfer")

    // a stalled result holds
    `FRC_ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // reset leaves no result pending
    `FRC_ASSERT_ALL(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind fifo_replacement_cache frc_checker #(.DEPTH(DEPTH)) u_frc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/tb.sv]
// self-checking bench for the fifo replacement cache: directed then random put, get and delete
// traffic with random idling on both streams, results compared against an in-bench cache model
// depends on frc_pkg and fifo_replacement_cache

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS = 1430;
    localparam int IDLE_PCT   = 27;
    localparam int MAX_PRINTS = 40;
    // command code with no meaning: must change nothing and answer a miss
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // result stream layout
    localparam int OCC_LO = WORD_W;
    localparam int PAD_LO = WORD_W + OCC_W;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] val;
        bit                drain_first;  // hold the item back until the result stream is empty
    } cache_req_t;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] data_out;
        logic [OCC_W-1:0]  occ;
    } cache_resp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // shadow copy of the store, oldest entry at index 0
    logic [WORD_W-1:0] shadow_keys[$];
    logic [WORD_W-1:0] shadow_vals[$];

    cache_req_t  pending_q[$];   // items still to be offered
    cache_resp_t expected_q[$];  // answers owed by the block, oldest first
    cache_req_t  in_flight;
    cache_resp_t want;

    int taken = 0;          // input transfers so far
    int mismatches = 0;
    int input_stalls = 0;   // cycles the block refused an offered item
    int stall_left = 0;
    bit stall_done = 1'b0;
    int status_seen[5] = '{default: 0};
    logic [WORD_W-1:0] key_pool[16];

    fifo_replacement_cache #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // key[31:0], data_in[63:32]
        .s_tuser (s_tuser),   // command[1:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // data_out[31:0], occupancy[35:32], zero pad[39:36]
        .m_tuser (m_tuser)    // status[2:0]
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predicted effect of one item on the cache, updates the shadow store
    function automatic cache_resp_t cache_apply(cache_req_t req);
        cache_resp_t r;
        int hit_at;
        r.status   = ST_MISS;
        r.data_out = '0;
        hit_at     = -1;
        // oldest matching entry wins, duplicates further up are shadowed
        foreach (shadow_keys[i]) begin
            if (hit_at < 0 && shadow_keys[i] == req.key) hit_at = i;
        end
        case (req.op)
            CMD_PUT: begin
                r.status = ST_STORED;
                if (shadow_keys.size() >= DEPTH) begin
                    // eviction drops the oldest entry completely
                    void'(shadow_keys.pop_front());
                    void'(shadow_vals.pop_front());
                    r.status = ST_EVICTED;
                end
                shadow_keys.push_back(req.key);
                shadow_vals.push_back(req.val);
            end
            CMD_GET: begin
                if (hit_at >= 0) begin
                    r.status   = ST_HIT;
                    r.data_out = shadow_vals[hit_at];
                end
            end
            CMD_DEL: begin
                if (hit_at >= 0) begin
                    // younger entries close the gap, order kept
                    shadow_keys.delete(hit_at);
                    shadow_vals.delete(hit_at);
                    r.status = ST_DELETED;
                end
            end
            default: ;
        endcase
        r.occ = OCC_W'(shadow_keys.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] exp_v);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch on %s: got %h, wanted %h", $realtime, what, got, exp_v);
    endtask

    function automatic void add_req(logic [CMD_W-1:0] op, logic [WORD_W-1:0] key,
                                    logic [WORD_W-1:0] val, bit drain_first);
        pending_q.push_back('{op, key, val, drain_first});
    endfunction

    // stretch of the run with no idling on either stream
    function automatic bit calm_window();
        return taken >= 700 && taken < 950;
    endfunction

    // sender: one item held on the bus until its transfer, then the next or a gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && !s_tready) input_stalls++;
            if (s_tvalid && s_tready) begin
                expected_q.push_back(cache_apply(in_flight));
                taken <= taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0
                    && !(pending_q[0].drain_first && expected_q.size() != 0)
                    && (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
                    in_flight = pending_q.pop_front();
                    s_tdata   <= {in_flight.val, in_flight.key};
                    s_tuser   <= in_flight.op;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off, so the block backs up and refuses input
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_done && taken >= 500) begin
            stall_left <= 250;
            stall_done <= 1'b1;
        end
    end

    // receiver readiness
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // result checker: every result transfer against the oldest owed answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unrequested result", m_tdata[WORD_W-1:0], '0);
            end else begin
                want = expected_q.pop_front();
                status_seen[want.status]++;
                if (m_tuser !== want.status)
                    report_mismatch("status", WORD_W'(m_tuser), WORD_W'(want.status));
                if (m_tdata[WORD_W-1:0] !== want.data_out)
                    report_mismatch("data_out", m_tdata[WORD_W-1:0], want.data_out);
                if (m_tdata[OCC_LO +: OCC_W] !== want.occ)
                    report_mismatch("occupancy", WORD_W'(m_tdata[OCC_LO +: OCC_W]),
                                    WORD_W'(want.occ));
                if (m_tdata[M_DATA_W-1:PAD_LO] !== '0)
                    report_mismatch("pad bits", WORD_W'(m_tdata[M_DATA_W-1:PAD_LO]), '0);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [CMD_W-1:0] op;
        logic [WORD_W-1:0] key;
        int roll;
        bit draining;

        // directed: empty store, unused code, extreme keys and values, duplicates,
        // filling up, eviction, deletes of the oldest entry and of a missing key
        add_req(CMD_GET,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(CMD_DEL,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_PUT,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_req(CMD_PUT,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_req(CMD_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_req(CMD_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(CMD_PUT,    32'h0000_0000, 32'h1234_5678, 1'b0);
        add_req(CMD_GET,    32'h0000_0000, 32'hDEAD_BEEF, 1'b0);
        add_req(CMD_PUT,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        add_req(CMD_PUT,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
        add_req(CMD_PUT,    32'h0000_0001, 32'h0000_0001, 1'b0);
        add_req(CMD_PUT,    32'h0000_0002, 32'h0000_0002, 1'b1);
        add_req(CMD_GET,    32'h8000_0000, 32'h0000_0000, 1'b0);
        add_req(CMD_DEL,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(CMD_DEL,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(CMD_GET,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(CMD_DEL,    32'h0000_1111, 32'h0000_0000, 1'b0);
        add_req(CMD_UNUSED, 32'h0000_0002, 32'h0000_0000, 1'b0);
        add_req(CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

        // small key pool so that gets and deletes hit and duplicates pile up
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        draining = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // alternate fill-heavy and drain-heavy stretches so the store
            // swings between empty and full
            if (n % 60 == 0) draining = ($urandom_range(2) == 0);
            roll = $urandom_range(99);
            if (draining)
                op = roll < 15 ? CMD_PUT : roll < 45 ? CMD_GET : roll < 95 ? CMD_DEL : CMD_UNUSED;
            else
                op = roll < 50 ? CMD_PUT : roll < 80 ? CMD_GET : roll < 95 ? CMD_DEL : CMD_UNUSED;
            key = ($urandom_range(9) == 0) ? 32'($urandom) : key_pool[$urandom_range(15)];
            add_req(op, key, $urandom, (n % 250) == 125);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d transfers: %0d stored, %0d stored with eviction, %0d hits, %0d misses, %0d deleted",
                 taken, status_seen[ST_STORED], status_seen[ST_EVICTED], status_seen[ST_HIT],
                 status_seen[ST_MISS], status_seen[ST_DELETED]);
        $display("input refused for %0d cycles, %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("watchdog expired: %0d items unsent, %0d results owed",
                 pending_q.size(), expected_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
